/* hw/rtl/gpd_pkg.sv */
`timescale 1ns / 1ps

package gpd_pkg;

   // mark bytes and header geometry
   localparam logic [7:0]  MARK_HI         = 8'hBC;
   localparam logic [7:0]  MARK_LO         = 8'hA1;
   localparam logic [15:0] MIN_CONTENT     = 16'd4;
   localparam logic [16:0] HEADER_BYTES    = 17'd4;
   localparam logic [16:0] RECORD_MIN      = 17'd8;
   localparam logic [16:0] GPS_MIN_AVAIL   = 17'd22;
   localparam logic [16:0] BIAS_MIN_AVAIL  = 17'd26;
   localparam logic [7:0]  LONG_BIAS_PLEN  = 8'd18;
   localparam logic [7:0]  SHORT_BIAS_PLEN = 8'd14;

   // payload bytes the decoder looks at
   localparam int DECODE_BYTES = 18;

   // coordinate limits in 1e-7 degree
   localparam logic signed [31:0] LAT_LIMIT_HI = 32'sd900000000;
   localparam logic signed [31:0] LAT_LIMIT_LO = -32'sd900000000;
   localparam logic signed [31:0] LON_LIMIT_HI = 32'sd1800000000;
   localparam logic signed [31:0] LON_LIMIT_LO = -32'sd1800000000;

   // csr indexes and reset values
   localparam logic [1:0]  CSR_GPS_TYPE_CODE    = 2'd0;
   localparam logic [1:0]  CSR_LONG_FORMAT_MIN  = 2'd1;
   localparam logic [1:0]  CSR_MAX_TOTAL_LENGTH = 2'd2;
   localparam logic [15:0] GPS_TYPE_CODE_RESET    = 16'd2054;
   localparam logic [7:0]  LONG_FORMAT_MIN_RESET  = 8'd39;
   localparam logic [16:0] MAX_TOTAL_LENGTH_RESET = 17'd1000;

   typedef enum logic [2:0] {
      HS_IDLE,
      HS_MARK1,
      HS_LENHI,
      HS_LENLO,
      HS_BODY
   } hunt_state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
   } req_payload_type;

   typedef struct packed {
      logic [15:0]        packet_id;
      logic [15:0]        content_length;
      logic [7:0]         header_flag;
      logic [7:0]         payload_length;
      logic [15:0]        status_word;
      logic [31:0]        time_of_week;
      logic signed [31:0] latitude;
      logic signed [31:0] longitude;
      logic signed [31:0] clock_bias;
      logic               fix_valid;
      logic               truncated;
   } rsp_payload_type;

   // captured header handed to the decoder
   typedef struct packed {
      logic [15:0] packet_id;
      logic [15:0] content_length;
      logic [7:0]  header_flag;
      logic [7:0]  payload_length;
      logic [16:0] avail;
      logic        truncated;
   } header_info_type;

endpackage

/* hw/rtl/gps_packet_deframer.sv */
`timescale 1ns / 1ps
// channel   ports                                   direction
// req       req_valid, req_ready, req_payload       in: one buffer byte per transfer
// rsp       rsp_valid, rsp_ready, rsp_payload       out: one record per packet
// csr       csr_write_en, csr_index, csr_wdata      in: register writes
//
// One byte is taken per cycle while req_ready is high; the byte that completes or
// truncates a packet loads its record into the output register, or the skid slot.
// The hunt state and header capture are updated on the same edge as the
// transfer; the record decode sits between them and the output register.
// Reset is synchronous and clears the hunt, counters and both output slots.
// A skid slot holds one record while the output stalls; req_ready drops only
// when that slot is also full.

module gps_packet_deframer
   import gpd_pkg::*;
#(
   parameter int CAPTURE_BYTES = 18
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_write_en,
   input  logic [1:0]      csr_index,
   input  logic [16:0]     csr_wdata
);

   localparam int IDX_W = $clog2(CAPTURE_BYTES);

   // configuration
   logic [15:0] gps_type_code_ff;
   logic [7:0]  long_format_min_ff;
   logic [16:0] max_total_length_ff;

   // hunt and header state
   hunt_state_type state_ff, state_in;
   logic [16:0]    byte_count_ff, byte_count_in;
   logic [15:0]    held_length_ff, held_length_in;
   logic [15:0]    held_type_ff, held_type_in;
   logic [7:0]     held_flag_ff, held_flag_in;
   logic [7:0]     held_plen_ff, held_plen_in;
   logic [7:0]     store_ff [CAPTURE_BYTES];

   // output slots
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;
   logic            skid_valid_ff;
   rsp_payload_type skid_data_ff;

   logic                          accept;
   logic [7:0]                    b;
   logic                          eob;
   logic [15:0]                   len_full;
   logic                          len_ok;
   logic [16:0]                   count_inc;
   logic                          body_done;
   logic [16:0]                   store_off;
   logic                          store_wr;
   logic [DECODE_BYTES-1:0][7:0]  store_view;
   logic                          emit_done;
   logic                          emit_trunc;
   logic                          emit;
   header_info_type               hdr;
   rsp_payload_type               rec;
   logic                          out_free;

   function automatic hunt_state_type search_step(input hunt_state_type s,
                                                  input logic [7:0] d);
      hunt_state_type r;
      if (s == HS_MARK1) begin
         if (d == MARK_LO) r = HS_LENHI;
         else if (d == MARK_HI) r = HS_MARK1;
         else r = HS_IDLE;
      end else begin
         r = (d == MARK_HI) ? HS_MARK1 : HS_IDLE;
      end
      return r;
   endfunction

   assign accept    = req_valid && req_ready;
   assign b         = req_payload.data_byte;
   assign eob       = req_payload.end_of_buffer;
   assign len_full  = {held_length_ff[15:8], b};
   assign len_ok    = (len_full >= MIN_CONTENT) &&
                      ((HEADER_BYTES + {1'b0, len_full}) <= max_total_length_ff);
   assign count_inc = byte_count_ff + 17'd1;
   assign body_done = count_inc == (HEADER_BYTES + {1'b0, held_length_ff});
   assign store_off = byte_count_ff - RECORD_MIN;
   assign store_wr  = (state_ff == HS_BODY) && (byte_count_ff >= RECORD_MIN) &&
                      (store_off < 17'(CAPTURE_BYTES));

   // next hunt state
   always_comb begin
      state_in = state_ff;
      if (accept) begin
         case (state_ff)
            HS_LENHI: begin
               state_in = HS_LENLO;
            end
            HS_LENLO: begin
               if (len_ok) state_in = HS_BODY;
               else state_in = search_step(search_step(HS_IDLE, held_length_ff[15:8]), b);
            end
            HS_BODY: begin
               if (body_done) state_in = HS_IDLE;
            end
            default: begin
               state_in = search_step(state_ff, b);
            end
         endcase
         if (eob) state_in = HS_IDLE;
      end
   end

   // header capture and byte count
   always_comb begin
      byte_count_in  = byte_count_ff;
      held_length_in = held_length_ff;
      held_type_in   = held_type_ff;
      held_flag_in   = held_flag_ff;
      held_plen_in   = held_plen_ff;
      if (accept) begin
         case (state_ff)
            HS_LENHI: begin
               held_length_in = {b, 8'h00};
            end
            HS_LENLO: begin
               held_length_in = len_full;
               if (len_ok) byte_count_in = HEADER_BYTES;
            end
            HS_BODY: begin
               case (byte_count_ff)
                  17'd4:   held_type_in = {b, 8'h00};
                  17'd5:   held_type_in = {held_type_ff[15:8], b};
                  17'd6:   held_flag_in = b;
                  17'd7:   held_plen_in = b;
                  default: ;
               endcase
               byte_count_in = body_done ? 17'd0 : count_inc;
            end
            default: ;
         endcase
         if (eob) byte_count_in = '0;
      end
   end

   // record triggers: last byte of the packet, or buffer end inside a packet once its header is in
   assign emit_done  = accept && (state_ff == HS_BODY) && body_done;
   assign emit_trunc = accept && eob && (state_ff == HS_BODY) && !body_done &&
                       (count_inc >= RECORD_MIN);
   assign emit       = emit_done || emit_trunc;

   // store contents including the byte in this transfer
   always_comb begin
      for (int i = 0; i < DECODE_BYTES; i++) begin
         store_view[i] = (store_wr && store_off == 17'(i)) ? b : store_ff[i];
      end
   end

   assign hdr.packet_id      = held_type_in;
   assign hdr.content_length = held_length_ff;
   assign hdr.header_flag    = held_flag_in;
   assign hdr.payload_length = held_plen_in;
   assign hdr.avail          = count_inc;
   assign hdr.truncated      = emit_trunc;

   gpd_decode u_decode (
      .hdr             (hdr),
      .store           (store_view),
      .gps_type_code   (gps_type_code_ff),
      .long_format_min (long_format_min_ff),
      .rec             (rec)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= HS_IDLE;
         byte_count_ff       <= '0;
         held_length_ff      <= '0;
         held_type_ff        <= '0;
         held_flag_ff        <= '0;
         held_plen_ff        <= '0;
         gps_type_code_ff    <= GPS_TYPE_CODE_RESET;
         long_format_min_ff  <= LONG_FORMAT_MIN_RESET;
         max_total_length_ff <= MAX_TOTAL_LENGTH_RESET;
      end else begin
         state_ff       <= state_in;
         byte_count_ff  <= byte_count_in;
         held_length_ff <= held_length_in;
         held_type_ff   <= held_type_in;
         held_flag_ff   <= held_flag_in;
         held_plen_ff   <= held_plen_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_GPS_TYPE_CODE:    gps_type_code_ff    <= csr_wdata[15:0];
               CSR_LONG_FORMAT_MIN:  long_format_min_ff  <= csr_wdata[7:0];
               CSR_MAX_TOTAL_LENGTH: max_total_length_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload capture
   always_ff @(posedge clock) begin
      if (accept && store_wr) begin
         store_ff[store_off[IDX_W-1:0]] <= b;
      end
   end

   // output register and skid slot
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= emit;
         end
      end else if (emit) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_data_ff <= skid_valid_ff ? skid_data_ff : rec;
      end else if (emit) begin
         skid_data_ff <= rec;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

/* hw/rtl/gpd_decode.sv */
`timescale 1ns / 1ps

module gpd_decode
   import gpd_pkg::*;
(
   input  header_info_type                   hdr,
   input  logic [DECODE_BYTES-1:0][7:0]      store,
   input  logic [15:0]                       gps_type_code,
   input  logic [7:0]                        long_format_min,
   output rsp_payload_type                   rec
);

   logic               is_gps;
   logic               long_layout;
   logic [15:0]        status;
   logic [31:0]        tow;
   logic signed [31:0] lat;
   logic signed [31:0] lon;
   logic signed [31:0] bias;
   logic               out_of_range;

   // position fields by layout
   always_comb begin
      is_gps      = (hdr.packet_id == gps_type_code) && (hdr.avail >= GPS_MIN_AVAIL);
      long_layout = hdr.payload_length >= long_format_min;
      status      = '0;
      tow         = '0;
      lat         = '0;
      lon         = '0;
      bias        = '0;
      if (is_gps) begin
         status = {store[0], store[1]};
         if (long_layout) begin
            tow = {store[2], store[3], store[4], store[5]};
            lat = {store[6], store[7], store[8], store[9]};
            lon = {store[10], store[11], store[12], store[13]};
            if (hdr.payload_length >= LONG_BIAS_PLEN && hdr.avail >= BIAS_MIN_AVAIL) begin
               bias = {store[14], store[15], store[16], store[17]};
            end
         end else begin
            lat = {store[2], store[3], store[4], store[5]};
            lon = {store[6], store[7], store[8], store[9]};
            if (hdr.payload_length >= SHORT_BIAS_PLEN) begin
               bias = {store[10], store[11], store[12], store[13]};
            end
         end
      end
   end

   // coordinate range check on raw integers
   assign out_of_range = (lat < LAT_LIMIT_LO) || (lat > LAT_LIMIT_HI) ||
                         (lon < LON_LIMIT_LO) || (lon > LON_LIMIT_HI);

   // record assembly
   always_comb begin
      rec.packet_id      = hdr.packet_id;
      rec.content_length = hdr.content_length;
      rec.header_flag    = hdr.header_flag;
      rec.payload_length = hdr.payload_length;
      rec.status_word    = status;
      rec.time_of_week   = tow;
      rec.latitude       = lat;
      rec.longitude      = lon;
      rec.clock_bias     = bias;
      rec.fix_valid      = hdr.header_flag[7] && !(is_gps && out_of_range);
      rec.truncated      = hdr.truncated;
   end

endmodule

/* hw/rtl/gpd_checker.sv */
`timescale 1ns / 1ps

module gpd_checker
   import gpd_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   // stalled record holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("record changed while stalled");

   // input back-pressure only with a stalled record in the output
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with empty output");

   // records come only from accepted headers
   a_min_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.content_length >= MIN_CONTENT)
      else $error("record with short content length");

   // valid fix needs flag bit and legal coordinates
   a_fix_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.fix_valid |->
         rsp_payload.header_flag[7] &&
         rsp_payload.latitude >= LAT_LIMIT_LO && rsp_payload.latitude <= LAT_LIMIT_HI &&
         rsp_payload.longitude >= LON_LIMIT_LO && rsp_payload.longitude <= LON_LIMIT_HI)
      else $error("fix marked valid against flag or range");

   // output empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("record present after reset");

endmodule

bind gps_packet_deframer gpd_checker u_gpd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
